>>> hw/rtl/bxds_pkg.sv
// Shared types and constants for the box average downscaler.
package bxds_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_SCALE  = 16;
    localparam int MAX_HEIGHT = 4096;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

    typedef struct packed {
        logic [7:0] pixel;
        logic       image_start;
    } in_t;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic       row_end;
        logic       image_end;
    } out_t;

    typedef struct packed {
        logic [15:0] sum;
        logic [8:0]  divisor;
        logic        row_end;
        logic        image_end;
    } blk_t;

    typedef struct packed {
        logic valid;
        blk_t data;
    } push_t;

endpackage

>>> hw/rtl/bxds_front.sv
// Front end: configuration, raster position tracking and block accumulation.
module bxds_front import bxds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    input  logic                  q_room,
    output push_t                 push
);

    logic [8:0]  width_reg;
    logic [12:0] height_reg;
    logic [4:0]  scale_reg;

    logic [8:0]  col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [3:0]  x_reg, x_next;
    logic [3:0]  y_reg, y_next;
    logic [8:0]  bx_reg, bx_next;
    logic [11:0] rsum_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_slot_reg;
    logic        s1_use_old_reg;
    logic [11:0] s1_rsum_reg;
    logic        s1_emit_reg;
    logic        s1_last_col_reg;
    logic        s1_last_row_reg;
    logic [15:0] rd_data_reg;
    logic [15:0] col_mem [MAX_WIDTH];

    logic [8:0]  w;
    logic [12:0] h;
    logic [4:0]  f;
    logic        start;
    logic [8:0]  col_e;
    logic [11:0] row_e;
    logic [3:0]  x_e;
    logic [3:0]  y_e;
    logic [8:0]  bx_e;
    logic [8:0]  col_base;
    logic [11:0] row_base;
    logic [9:0]  col_fit_end;
    logic [9:0]  col_next_end;
    logic [13:0] row_fit_end;
    logic [13:0] row_next_end;
    logic        in_block;
    logic [4:0]  x1;
    logic [4:0]  y1;
    logic        col_done;
    logic        blk_row_done;
    logic [11:0] rsum_new;
    logic [9:0]  col1;
    logic [12:0] row1;
    logic        accept;
    logic        fire;
    logic [15:0] s1_sum;
    logic [8:0]  f_sq;

    always_comb
    begin
        if (width_reg == 9'd0)
        begin
            w = 9'd1;
        end
        else if (width_reg > 9'(MAX_WIDTH))
        begin
            w = 9'(MAX_WIDTH);
        end
        else
        begin
            w = width_reg;
        end
        if (height_reg == 13'd0)
        begin
            h = 13'd1;
        end
        else if (height_reg > 13'(MAX_HEIGHT))
        begin
            h = 13'(MAX_HEIGHT);
        end
        else
        begin
            h = height_reg;
        end
        if (scale_reg == 5'd0)
        begin
            f = 5'd1;
        end
        else if (scale_reg > 5'(MAX_SCALE))
        begin
            f = 5'(MAX_SCALE);
        end
        else
        begin
            f = scale_reg;
        end
    end

    assign start    = in_data.image_start;
    assign col_e    = start ? '0 : col_reg;
    assign row_e    = start ? '0 : row_reg;
    assign x_e      = start ? '0 : x_reg;
    assign y_e      = start ? '0 : y_reg;
    assign bx_e     = start ? '0 : bx_reg;

    assign col_base     = col_e - {5'd0, x_e};
    assign row_base     = row_e - {8'd0, y_e};
    assign col_fit_end  = {1'b0, col_base} + {5'd0, f};
    assign col_next_end = {1'b0, col_base} + {4'd0, f, 1'b0};
    assign row_fit_end  = {2'b0, row_base} + {9'd0, f};
    assign row_next_end = {2'b0, row_base} + {8'd0, f, 1'b0};
    assign in_block     = (col_fit_end <= {1'b0, w}) && (row_fit_end <= {1'b0, h});

    assign x1           = {1'b0, x_e} + 5'd1;
    assign y1           = {1'b0, y_e} + 5'd1;
    assign col_done     = x1 >= f;
    assign blk_row_done = y1 >= f;
    assign rsum_new     = ((x_e == 4'd0) ? 12'd0 : rsum_reg) + {4'd0, in_data.pixel};

    assign in_ready = q_room;
    assign accept   = in_valid && in_ready;
    assign fire     = accept && in_block && col_done;

    assign col1 = {1'b0, col_e} + 10'd1;
    assign row1 = {1'b0, row_e} + 13'd1;

    always_comb
    begin
        col_next = col1[8:0];
        row_next = row_e;
        x_next   = col_done ? 4'd0 : x1[3:0];
        y_next   = y_e;
        bx_next  = col_done ? (bx_e + 9'd1) : bx_e;
        if (col1 >= {1'b0, w})
        begin
            col_next = '0;
            x_next   = '0;
            bx_next  = '0;
            if (row1 >= h)
            begin
                row_next = '0;
                y_next   = '0;
            end
            else
            begin
                row_next = row1[11:0];
                y_next   = blk_row_done ? 4'd0 : y1[3:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= 9'd28;
            height_reg   <= 13'd28;
            scale_reg    <= 5'd2;
            col_reg      <= '0;
            row_reg      <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            bx_reg       <= '0;
            rsum_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= fire;
            if (cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT ||
                           cfg_index == REG_SCALE_FACTOR))
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                begin
                    width_reg <= cfg_data[8:0];
                end
                if (cfg_index == REG_IMAGE_HEIGHT)
                begin
                    height_reg <= cfg_data;
                end
                if (cfg_index == REG_SCALE_FACTOR)
                begin
                    scale_reg <= cfg_data[4:0];
                end
                col_reg  <= '0;
                row_reg  <= '0;
                x_reg    <= '0;
                y_reg    <= '0;
                bx_reg   <= '0;
                rsum_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                x_reg   <= x_next;
                y_reg   <= y_next;
                bx_reg  <= bx_next;
                if (in_block)
                begin
                    rsum_reg <= rsum_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_slot_reg     <= bx_e[7:0];
            s1_use_old_reg  <= y_e != 4'd0;
            s1_rsum_reg     <= rsum_new;
            s1_emit_reg     <= blk_row_done;
            s1_last_col_reg <= col_next_end > {1'b0, w};
            s1_last_row_reg <= row_next_end > {1'b0, h};
        end
    end

    // Column sum memory: read on each request that completes a block's columns in a row, written in the cycle after.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            col_mem[s1_slot_reg] <= s1_sum;
        end
        if (fire)
        begin
            rd_data_reg <= col_mem[bx_e[7:0]];
        end
    end

    assign s1_sum = (s1_use_old_reg ? rd_data_reg : 16'd0) + {4'd0, s1_rsum_reg};
    assign f_sq   = {4'd0, f} * {4'd0, f};

    assign push.valid          = s1_valid_reg && s1_emit_reg;
    assign push.data.sum       = s1_sum;
    assign push.data.divisor   = f_sq;
    assign push.data.row_end   = s1_last_col_reg;
    assign push.data.image_end = s1_last_col_reg && s1_last_row_reg;

endmodule

>>> hw/rtl/bxds_queue.sv
// Short queue of finished block sums between the front end and the divider.
module bxds_queue import bxds_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room,
    output logic  pop_valid,
    input  logic  pop_ready,
    output blk_t  pop_data
);

    blk_t                entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                pop;

    // Room for two keeps space for a request still in the accumulation stage.
    assign room      = count_reg <= (QPTR_W+1)'(QDEPTH - 2);
    assign pop_valid = count_reg != '0;
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push.valid && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push.valid && pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

>>> hw/rtl/bxds_divider.sv
// Back end: restoring divider for block averages and the output register.
module bxds_divider import bxds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_ready,
    input  blk_t q_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] quo_reg;
    logic [8:0]  rem_reg;
    logic [8:0]  div_reg;
    logic [3:0]  step_reg;
    logic        row_end_reg;
    logic        image_end_reg;
    logic        out_valid_reg;
    out_t        out_reg;

    logic [9:0]  trial;
    logic [8:0]  diff;
    logic        ge;
    logic        load_out;

    assign trial    = {rem_reg, quo_reg[15]};
    assign diff     = trial[8:0] - div_reg;
    assign ge       = trial >= {1'b0, div_reg};
    assign q_ready  = state_reg == ST_IDLE;
    assign load_out = (state_reg == ST_HOLD) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == 4'd15)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DIV)
            begin
                step_reg <= step_reg + 4'd1;
            end
            else
            begin
                step_reg <= '0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            quo_reg       <= q_data.sum;
            rem_reg       <= '0;
            div_reg       <= q_data.divisor;
            row_end_reg   <= q_data.row_end;
            image_end_reg <= q_data.image_end;
        end
        else if (state_reg == ST_DIV)
        begin
            quo_reg <= {quo_reg[14:0], ge};
            rem_reg <= ge ? diff : trial[8:0];
        end
        if (load_out)
        begin
            out_reg.out_pixel <= quo_reg[7:0];
            out_reg.row_end   <= row_end_reg;
            out_reg.image_end <= image_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> hw/rtl/box_average_downscale.sv
// Top level of the box average downscaler.
// Pixels are taken one per cycle while the result queue has room for two more block sums.
// Block sums are registered, queued, divided when the divider is idle, and output from a register.
// Each result holds the sequential 16-step divider, which takes a new block sum only once it is idle.
// Reset sets width and height to 28 and the factor to 2 and clears all control state.
// The column sum memory is not cleared; each entry is written before it is read.
module box_average_downscale import bxds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data
);

    push_t push;
    logic  q_room;
    logic  q_valid;
    logic  q_ready;
    blk_t  q_data;

    bxds_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_room    (q_room),
        .push      (push)
    );

    bxds_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (q_room),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_data)
    );

    bxds_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the box average downscaler: directed and random pixel streams.
module tb_top;
    import bxds_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_PRINTED   = 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        in_t                   req;
        logic                  pinned;
        out_t                  want;
    } step_t;

    typedef struct packed {
        logic pinned;
        out_t want;
    } pin_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_t                   in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_t                  out_data;

    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int error_count = 0;
    int pixels_taken = 0;
    int averages_checked = 0;
    int reg_writes = 0;
    int settings_used = 0;

    out_t pending_averages[$];
    pin_t pin_q[$];

    logic [8:0]  reg_width = 9'd28;
    logic [12:0] reg_height = 13'd28;
    logic [4:0]  reg_factor = 5'd2;
    logic [15:0] col_sum [MAX_WIDTH];
    logic [11:0] row_sum = '0;
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    logic [3:0]  x_in = '0;
    logic [3:0]  y_in = '0;

    int ext_w [4] = '{0, 511, 16, 256};
    int ext_h [4] = '{0, 8191, 16, 1};
    int ext_f [4] = '{0, 31, 16, 1};
    logic [CFG_IDX_W-1:0] reg_order [3] = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_SCALE_FACTOR};

    localparam out_t NONE = '0;

    step_t script [31] = '{
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd17, 1'b1}, 1'b0, NONE},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd99, 1'b0}, 1'b0, NONE},
        '{STEP_WRITE, REG_IMAGE_WIDTH, 13'd4, '{8'd0, 1'b0}, 1'b0, NONE},
        '{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd2, '{8'd0, 1'b0}, 1'b0, NONE},
        '{STEP_WRITE, REG_SCALE_FACTOR, 13'd1, '{8'd0, 1'b0}, 1'b0, NONE},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd0, 1'b1}, 1'b1, '{8'd0, 1'b0, 1'b0}},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd255, 1'b0}, 1'b1, '{8'd255, 1'b0, 1'b0}},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd1, 1'b0}, 1'b1, '{8'd1, 1'b0, 1'b0}},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd128, 1'b0}, 1'b1, '{8'd128, 1'b1, 1'b0}},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd7, 1'b0}, 1'b1, '{8'd7, 1'b0, 1'b0}},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd8, 1'b0}, 1'b1, '{8'd8, 1'b0, 1'b0}},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd9, 1'b0}, 1'b1, '{8'd9, 1'b0, 1'b0}},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd10, 1'b0}, 1'b1, '{8'd10, 1'b1, 1'b1}},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd33, 1'b0}, 1'b1, '{8'd33, 1'b0, 1'b0}},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd44, 1'b1}, 1'b1, '{8'd44, 1'b0, 1'b0}},
        '{STEP_WRITE, REG_IMAGE_WIDTH, 13'd2, '{8'd0, 1'b0}, 1'b0, NONE},
        '{STEP_WRITE, REG_SCALE_FACTOR, 13'd2, '{8'd0, 1'b0}, 1'b0, NONE},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd255, 1'b1}, 1'b0, NONE},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd255, 1'b0}, 1'b0, NONE},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd255, 1'b0}, 1'b0, NONE},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd255, 1'b0}, 1'b1, '{8'd255, 1'b1, 1'b1}},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd1, 1'b0}, 1'b0, NONE},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd2, 1'b0}, 1'b0, NONE},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd3, 1'b0}, 1'b0, NONE},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd4, 1'b0}, 1'b1, '{8'd2, 1'b1, 1'b1}},
        '{STEP_WRITE, REG_SCALE_FACTOR, 13'd0, '{8'd0, 1'b0}, 1'b0, NONE},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd5, 1'b1}, 1'b1, '{8'd5, 1'b0, 1'b0}},
        '{STEP_WRITE, REG_SCALE_FACTOR, 13'd31, '{8'd0, 1'b0}, 1'b0, NONE},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd9, 1'b1}, 1'b0, NONE},
        '{STEP_WRITE, REG_UNUSED, 13'h1FFF, '{8'd0, 1'b0}, 1'b0, NONE},
        '{STEP_PIXEL, REG_UNUSED, 13'd0, '{8'd3, 1'b0}, 1'b0, NONE}
    };

    box_average_downscale dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned clip(input int unsigned v, input int unsigned lo,
                                         input int unsigned hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic void clear_position();
        row_sum = '0;
        col_pos = 0;
        row_pos = 0;
        x_in = '0;
        y_in = '0;
    endfunction

    // Advances the raster position by one pixel and returns 1 when a block completes.
    function automatic bit predict_block_average(input in_t req, output out_t avg);
        int unsigned f, w, h, nw, nh, bx, by;
        logic [15:0] block_sum;
        bit done;
        f = clip(reg_factor, 1, MAX_SCALE);
        w = clip(reg_width, 1, MAX_WIDTH);
        h = clip(reg_height, 1, MAX_HEIGHT);
        nw = w / f;
        nh = h / f;
        done = 1'b0;
        avg = '0;
        if (req.image_start)
        begin
            clear_position();
        end
        if (col_pos < nw * f && row_pos < nh * f)
        begin
            row_sum = (x_in == 0 ? 12'd0 : row_sum) + req.pixel;
            if (x_in + 1 >= f)
            begin
                bx = col_pos / f;
                by = row_pos / f;
                block_sum = (y_in == 0 ? 16'd0 : col_sum[bx % MAX_WIDTH]) + row_sum;
                col_sum[bx % MAX_WIDTH] = block_sum;
                if (y_in + 1 >= f)
                begin
                    avg.out_pixel = 8'(block_sum / (f * f));
                    avg.row_end = (bx + 1 == nw);
                    avg.image_end = (bx + 1 == nw) && (by + 1 == nh);
                    done = 1'b1;
                end
            end
        end
        col_pos++;
        x_in = (x_in + 1 >= f) ? 4'd0 : x_in + 4'd1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            x_in = '0;
            row_pos++;
            y_in = (y_in + 1 >= f) ? 4'd0 : y_in + 4'd1;
            if (row_pos >= h)
            begin
                row_pos = 0;
                y_in = '0;
            end
        end
        return done;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_averages.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input in_t req, input logic pinned, input out_t want);
        pin_t pin;
        pin.pinned = pinned;
        pin.want = want;
        pin_q.push_back(pin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge clk)
    begin
        out_t want;
        out_t avg;
        pin_t pin;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                averages_checked++;
                if (pending_averages.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d with no block average pending",
                                              out_data.out_pixel));
                end
                else
                begin
                    want = pending_averages.pop_front();
                    if (out_data.out_pixel !== want.out_pixel)
                    begin
                        report_mismatch($sformatf("average got %0d, expected %0d",
                                                  out_data.out_pixel, want.out_pixel));
                    end
                    if (out_data.row_end !== want.row_end)
                    begin
                        report_mismatch($sformatf("row end got %b, expected %b",
                                                  out_data.row_end, want.row_end));
                    end
                    if (out_data.image_end !== want.image_end)
                    begin
                        report_mismatch($sformatf("image end got %b, expected %b",
                                                  out_data.image_end, want.image_end));
                    end
                end
            end
            if (cfg_we)
            begin
                reg_writes++;
                case (cfg_index)
                    REG_IMAGE_WIDTH:  reg_width = cfg_data[8:0];
                    REG_IMAGE_HEIGHT: reg_height = cfg_data;
                    REG_SCALE_FACTOR: reg_factor = cfg_data[4:0];
                    default: ;
                endcase
                if (cfg_index != REG_UNUSED)
                begin
                    clear_position();
                end
            end
            if (in_valid && in_ready)
            begin
                pixels_taken++;
                pin = pin_q.pop_front();
                if (predict_block_average(in_data, avg) && !pin.pinned)
                begin
                    pending_averages.push_back(avg);
                end
                if (pin.pinned)
                begin
                    pending_averages.push_back(pin.want);
                end
            end
        end
    end

    initial
    begin
        int w_set, h_set, f_set, ew, eh, image_len, budget, pos, rot, k_ext;
        bit extreme_set, stray;
        in_t req;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
        begin
            if (script[r].kind == STEP_WRITE)
            begin
                write_reg(script[r].idx, script[r].data);
            end
            else
            begin
                send_pixel(script[r].req, script[r].pinned, script[r].want);
            end
        end

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 49 : 0;
            out_stall_pct = (mode == 0) ? 49 : (mode == 1) ? 6 : 0;
            for (int e = 0; e < 6; e++)
            begin
                extreme_set = (e == 0) || (mode == 2 && e == 1);
                k_ext = (e == 0) ? mode : 3;
                if (extreme_set)
                begin
                    w_set = ext_w[k_ext];
                    h_set = ext_h[k_ext];
                    f_set = ext_f[k_ext];
                end
                else if ($urandom_range(9) < 7)
                begin
                    f_set = $urandom_range(1, 4);
                    w_set = f_set * $urandom_range(1, 3) + $urandom_range(0, f_set - 1);
                    h_set = f_set * $urandom_range(1, 3) + $urandom_range(0, f_set - 1);
                end
                else
                begin
                    w_set = $urandom_range(0, 511);
                    h_set = $urandom_range(0, 8191);
                    f_set = $urandom_range(0, 31);
                end
                ew = clip(w_set, 1, MAX_WIDTH);
                eh = clip(h_set, 1, MAX_HEIGHT);
                image_len = ew * eh;
                if (extreme_set)
                begin
                    budget = clip(image_len, 40, 256);
                end
                else
                begin
                    budget = image_len * $urandom_range(1, 3);
                    if (budget > 50)
                    begin
                        budget = $urandom_range(30, 50);
                    end
                end

                rot = $urandom_range(0, 2);
                for (int k = 0; k < 3; k++)
                begin
                    idx = reg_order[(rot + k) % 3];
                    if (idx == REG_IMAGE_WIDTH)
                    begin
                        data = {4'($urandom_range(15)), 9'(w_set)};
                    end
                    else if (idx == REG_IMAGE_HEIGHT)
                    begin
                        data = 13'(h_set);
                    end
                    else
                    begin
                        data = {8'($urandom_range(255)), 5'(f_set)};
                    end
                    write_reg(idx, data);
                end

                pos = 0;
                for (int i = 0; i < budget; i++)
                begin
                    stray = ($urandom_range(99) < 2);
                    if (stray)
                    begin
                        pos = 0;
                    end
                    req.image_start = stray || (pos == 0 && $urandom_range(1) == 1);
                    if (extreme_set && k_ext == 2)
                    begin
                        req.pixel = 8'd255;
                    end
                    else
                    begin
                        case ($urandom_range(7))
                            0:       req.pixel = 8'd0;
                            1:       req.pixel = 8'd255;
                            default: req.pixel = 8'($urandom);
                        endcase
                    end
                    send_pixel(req, 1'b0, NONE);
                    pos = (pos + 1 == image_len) ? 0 : pos + 1;
                end
                settings_used++;
            end
        end

        wait_idle();
        $display("Covered %0d pixel requests and %0d block averages over %0d register writes",
                 pixels_taken, averages_checked, reg_writes);
        $display("and %0d random settings, with both sides stalling and running free.",
                 settings_used);
        if (error_count == 0)
        begin
            $display("box_average_downscale: match");
        end
        else
        begin
            $display("box_average_downscale: mismatch");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("box_average_downscale: mismatch");
        $finish;
    end

endmodule

>>> box_average_downscale.f
hw/rtl/bxds_pkg.sv
hw/rtl/bxds_front.sv
hw/rtl/bxds_queue.sv
hw/rtl/bxds_divider.sv
hw/rtl/box_average_downscale.sv
test/tb_top.sv
